// ===== hw/rtl/lpsg_pkg.sv =====
`default_nettype none

package lpsg_pkg;

    // Panel size limits
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 256;

    // Field widths
    localparam int POS_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int PWID_W  = 8;
    localparam int PHGT_W  = 9;
    localparam int PKT_W   = 7;
    localparam int SLOT_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIRING_CORNER = 3'd4;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Start corner of the serpentine chain
    typedef enum logic [1:0] {
        CORNER_DOWN_LEFT  = 2'd0,
        CORNER_DOWN_RIGHT = 2'd1,
        CORNER_TOP_LEFT   = 2'd2,
        CORNER_TOP_RIGHT  = 2'd3
    } corner_t;

    typedef struct packed {
        logic [PWID_W-1:0] panel_width;
        logic [PHGT_W-1:0] panel_height;
        logic [POS_W-1:0]  window_left;
        logic [POS_W-1:0]  window_top;
        corner_t           wiring_corner;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic              keep;
        logic [PKT_W-1:0]  packet_index;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } result_t;

    typedef logic [255:0][CHAN_W-1:0] rom_t;

    // Gamma 2.2 table: largest v with v^5 * 255^6 <= i^11, evaluated at elaboration
    function automatic rom_t red_rom_f();
        rom_t                   rom;
        logic [255:0][127:0]    pow5;
        logic [127:0]           k6;
        logic [127:0]           lim;
        int                     v;
        rom  = '0;
        k6   = 128'd1;
        for (int k = 0; k < 6; k++) k6 = k6 * 128'd255;
        for (int c = 0; c < 256; c++) begin
            pow5[c] = 128'd1;
            for (int k = 0; k < 5; k++) pow5[c] = pow5[c] * 128'(c);
        end
        for (int i = 0; i < 256; i++) begin
            lim = 128'd1;
            for (int k = 0; k < 11; k++) lim = lim * 128'(i);
            v = 0;
            for (int c = 1; c < 256; c++) begin
                if (pow5[c] * k6 <= lim) v = c;
            end
            rom[i] = CHAN_W'(v);
        end
        return rom;
    endfunction

    // Gamma 2 table: floor(i*i/255)
    function automatic rom_t square_rom_f();
        rom_t rom;
        rom = '0;
        for (int i = 0; i < 256; i++) rom[i] = CHAN_W'((i * i) / 255);
        return rom;
    endfunction

    localparam rom_t RED_ROM    = red_rom_f();
    localparam rom_t SQUARE_ROM = square_rom_f();

endpackage

`default_nettype wire

// ===== hw/rtl/led_panel_serpentine_gamma_map_unit.sv =====
`default_nettype none

// Serpentine LED panel mapper with gamma correction. Each pixel transfer on the
// s_ side carries frame coordinates and raw RGB; pixels outside the configured
// window (including the last row of an odd-height panel) are dropped, the rest
// leave on the m_ side as a row-pair packet index, an LED slot within that packet
// and gamma-corrected colors (red 2.2, green/blue 2.0). One pixel is taken every
// clock while the m_ side does not stall; a kept pixel passes from the input
// register through the single mapping stage into the result register. Registers
// are written through the cfg_ port, which is always ready; write them only while
// no pixel is in flight.
module led_panel_serpentine_gamma_map_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lpsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lpsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Pixel input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // pos_x[11:0], pos_y[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
    input  wire logic [lpsg_pkg::S_TDATA_W-1:0]      s_tdata,
    // Mapped LED output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // packet_index[6:0], slot[14:7], red_out[22:15], green_out[30:23],
    // blue_out[38:31], zero[39]
    output logic [lpsg_pkg::M_TDATA_W-1:0]           m_tdata
);

    lpsg_pkg::cfg_t    cfg;
    lpsg_pkg::pixel_t  pix_reg;
    lpsg_pkg::result_t res;
    lpsg_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_ready;

    lpsg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpsg_map u_map (
        .cfg (cfg),
        .pix (pix_reg),
        .res (res)
    );

    // Flow control: each stage moves when the stage after it can take data
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pix_reg.pos_x <= s_tdata[11:0];
            pix_reg.pos_y <= s_tdata[23:12];
            pix_reg.red   <= s_tdata[31:24];
            pix_reg.green <= s_tdata[39:32];
            pix_reg.blue  <= s_tdata[47:40];
        end
    end

    // Result register; dropped pixels leave no result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg && res.keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.blue, out_reg.green, out_reg.red,
                       out_reg.slot, out_reg.packet_index};

endmodule

`default_nettype wire

// ===== hw/rtl/lpsg_cfg.sv =====
`default_nettype none

module lpsg_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lpsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lpsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lpsg_pkg::cfg_t                           cfg
);

    lpsg_pkg::cfg_t cfg_reg;
    lpsg_pkg::cfg_t cfg_next;

    // Writes are taken every cycle
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode; unknown indexes are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpsg_pkg::REG_PANEL_WIDTH:
                    cfg_next.panel_width = cfg_data[lpsg_pkg::PWID_W-1:0];
                lpsg_pkg::REG_PANEL_HEIGHT:
                    cfg_next.panel_height = cfg_data[lpsg_pkg::PHGT_W-1:0];
                lpsg_pkg::REG_WINDOW_LEFT:
                    cfg_next.window_left = cfg_data[lpsg_pkg::POS_W-1:0];
                lpsg_pkg::REG_WINDOW_TOP:
                    cfg_next.window_top = cfg_data[lpsg_pkg::POS_W-1:0];
                lpsg_pkg::REG_WIRING_CORNER:
                    cfg_next.wiring_corner = lpsg_pkg::corner_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width   <= 8'd64;
            cfg_reg.panel_height  <= 9'd32;
            cfg_reg.window_left   <= '0;
            cfg_reg.window_top    <= '0;
            cfg_reg.wiring_corner <= lpsg_pkg::CORNER_DOWN_LEFT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpsg_map.sv =====
`default_nettype none

module lpsg_map (
    input  wire lpsg_pkg::cfg_t    cfg,
    input  wire lpsg_pkg::pixel_t  pix,
    output lpsg_pkg::result_t      res
);

    logic [lpsg_pkg::PWID_W-1:0]  w;
    logic [lpsg_pkg::PHGT_W-1:0]  h;
    logic [7:0]                   pairs;
    logic [lpsg_pkg::PHGT_W-1:0]  row_lim;
    logic [lpsg_pkg::POS_W-1:0]   lx;
    logic [lpsg_pkg::POS_W-1:0]   ly;
    logic                         in_win;
    logic [7:0]                   lx8;
    logic [lpsg_pkg::PKT_W-1:0]   p;
    logic                         odd;
    logic [lpsg_pkg::PKT_W-1:0]   pkt_rev;
    logic [lpsg_pkg::SLOT_W-1:0]  w2m1;
    logic [lpsg_pkg::SLOT_W-1:0]  slot_a;
    logic [lpsg_pkg::SLOT_W-1:0]  slot_b;
    logic [lpsg_pkg::SLOT_W-1:0]  slot_c;

    // Clamp panel size
    assign w = (cfg.panel_width > 8'(lpsg_pkg::MAX_WIDTH)) ?
               8'(lpsg_pkg::MAX_WIDTH) : cfg.panel_width;
    assign h = (cfg.panel_height > 9'(lpsg_pkg::MAX_HEIGHT)) ?
               9'(lpsg_pkg::MAX_HEIGHT) : cfg.panel_height;
    assign pairs   = h[8:1];
    assign row_lim = {pairs, 1'b0};

    // Window-relative position and window test (odd last row falls outside)
    assign lx = pix.pos_x - cfg.window_left;
    assign ly = pix.pos_y - cfg.window_top;
    assign in_win = (pix.pos_x >= cfg.window_left) && (pix.pos_y >= cfg.window_top)
                 && (lx < {4'b0, w}) && (ly < {3'b0, row_lim});

    assign lx8 = lx[7:0];
    assign p   = ly[7:1];
    assign odd = ly[0];

    // Candidate packet and slot values, all modulo the field widths
    assign pkt_rev = pairs[6:0] - 7'd1 - p;
    assign w2m1    = {w[6:0], 1'b0} - 8'd1;
    assign slot_a  = w2m1 - lx8;
    assign slot_b  = w - 8'd1 - lx8;
    assign slot_c  = w + lx8;

    always_comb begin
        res.keep = in_win;
        unique case (cfg.wiring_corner)
            lpsg_pkg::CORNER_DOWN_LEFT: begin
                res.packet_index = pkt_rev;
                res.slot         = odd ? lx8 : slot_a;
            end
            lpsg_pkg::CORNER_DOWN_RIGHT: begin
                res.packet_index = pkt_rev;
                res.slot         = odd ? slot_b : slot_c;
            end
            lpsg_pkg::CORNER_TOP_LEFT: begin
                res.packet_index = p;
                res.slot         = odd ? slot_c : slot_b;
            end
            default: begin
                res.packet_index = p;
                res.slot         = odd ? slot_a : lx8;
            end
        endcase
        // Gamma lookups
        res.red   = lpsg_pkg::RED_ROM[pix.red];
        res.green = lpsg_pkg::SQUARE_ROM[pix.green];
        res.blue  = lpsg_pkg::SQUARE_ROM[pix.blue];
    end

endmodule

`default_nettype wire
